// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL; each expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define UPE_ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define UPE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/upe_pkg.sv
package upe_pkg;

    localparam int MAX_RESULTS = 7;
    localparam int COUNT_W     = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] PCT = 8'h25;
    localparam logic [15:0][7:0] HEX_DIGITS = "FEDCBA9876543210";

    typedef enum logic [1:0] {
        HELD_NONE,
        HELD_PCT,
        HELD_PCT_DIGIT
    } held_stage_t;

    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_RAW,
        TAIL_ESC
    } tail_t;

    // One item's worth of encoded bytes, bytes[0] goes out first.
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] bytes;
        logic [COUNT_W-1:0]          count;
        logic                        str_last;
    } entry_t;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") ||
               (c >= "a" && c <= "f");
    endfunction

    function automatic logic passes(input logic [7:0] c);
        logic res;
        res = (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
              (c >= "0" && c <= "9");
        case (c)
            "-", ".", "_", "~", "!", "$", "&", "'", "(", ")", "*",
            "+", ",", ";", "=", ":", "@", "/", "?", "[", "]": res = 1'b1;
            default: ;
        endcase
        return res;
    endfunction

endpackage

// File: rtl/upe_in_if.sv
interface upe_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       is_last;

    modport source (output valid, output in_byte, output is_last, input ready);
    modport sink   (input valid, input in_byte, input is_last, output ready);
endinterface

// File: rtl/upe_out_if.sv
interface upe_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_last;

    modport source (output valid, output out_byte, output run_last,
                    output string_last, input ready);
    modport sink   (input valid, input out_byte, input run_last,
                    input string_last, output ready);
endinterface

// File: rtl/upe_front.sv
`include "assert_macros.svh"

module upe_front import upe_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    upe_in_if.sink        in_ch,
    input  logic          full,
    output logic          push,
    output entry_t        push_entry
);

    held_stage_t held_stage_reg, held_stage_next;
    logic [7:0]  held_digit_reg, held_digit_next;

    logic               accept;
    logic [7:0]         b;
    logic               last;
    logic               pct25;
    logic               pct_one;
    logic               emit_digit;
    logic               do_fresh;
    tail_t              tail;
    logic [COUNT_W-1:0] n;

    assign b           = in_ch.in_byte;
    assign last        = in_ch.is_last;
    assign in_ch.ready = !full;
    assign accept      = in_ch.valid && in_ch.ready;

    // Classify the item against what is held back.
    always_comb
    begin
        pct25           = 1'b0;
        pct_one         = 1'b0;
        emit_digit      = 1'b0;
        do_fresh        = 1'b0;
        tail            = TAIL_NONE;
        held_stage_next = HELD_NONE;
        held_digit_next = held_digit_reg;
        case (held_stage_reg)
            HELD_PCT:
            begin
                if (is_hex(b))
                begin
                    if (last)
                    begin
                        pct25 = 1'b1;
                        tail  = TAIL_RAW;
                    end
                    else
                    begin
                        held_stage_next = HELD_PCT_DIGIT;
                        held_digit_next = b;
                    end
                end
                else
                begin
                    pct25    = 1'b1;
                    do_fresh = 1'b1;
                end
            end
            HELD_PCT_DIGIT:
            begin
                emit_digit = 1'b1;
                if (is_hex(b))
                begin
                    pct_one = 1'b1;
                    tail    = TAIL_RAW;
                end
                else
                begin
                    pct25    = 1'b1;
                    do_fresh = 1'b1;
                end
            end
            default:
                do_fresh = 1'b1;
        endcase
        if (do_fresh)
        begin
            if (b == PCT)
            begin
                if (last)
                    tail = TAIL_ESC;
                else
                    held_stage_next = HELD_PCT;
            end
            else if (passes(b))
                tail = TAIL_RAW;
            else
                tail = TAIL_ESC;
        end
        if (last)
        begin
            held_stage_next = HELD_NONE;
            held_digit_next = '0;
        end
    end

    // Lay the bytes out in order of emission.
    always_comb
    begin
        push_entry       = '0;
        n                = '0;
        if (pct25)
        begin
            push_entry.bytes[0] = PCT;
            push_entry.bytes[1] = "2";
            push_entry.bytes[2] = "5";
            n = 3'd3;
        end
        else if (pct_one)
        begin
            push_entry.bytes[0] = PCT;
            n = 3'd1;
        end
        if (emit_digit)
        begin
            push_entry.bytes[n] = held_digit_reg;
            n = n + 3'd1;
        end
        case (tail)
            TAIL_RAW:
            begin
                push_entry.bytes[n] = b;
                n = n + 3'd1;
            end
            TAIL_ESC:
            begin
                push_entry.bytes[n]         = PCT;
                push_entry.bytes[n + 3'd1]  = HEX_DIGITS[b[7:4]];
                push_entry.bytes[n + 3'd2]  = HEX_DIGITS[b[3:0]];
                n = n + 3'd3;
            end
            default: ;
        endcase
        push_entry.count    = n;
        push_entry.str_last = last;
    end

    // Items that only hold bytes produce nothing downstream.
    assign push = accept && (n != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_stage_reg <= HELD_NONE;
            held_digit_reg <= '0;
        end
        else if (accept)
        begin
            held_stage_reg <= held_stage_next;
            held_digit_reg <= held_digit_next;
        end
    end

    `UPE_ASSERT_NEXT(a_empty_after_last, accept && last, held_stage_reg == HELD_NONE, "lookahead survives end of string")
    `UPE_ASSERT_IMPLIES(a_no_push_when_full, push, !full, "push into full queue")

endmodule

// File: rtl/upe_queue.sv
`include "assert_macros.svh"

module upe_queue import upe_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    input  logic   pop,
    output entry_t pop_data,
    output logic   full,
    output logic   empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    `UPE_ASSERT_IMPLIES(a_no_underflow, pop, !empty, "pop from empty queue")
    `UPE_ASSERT_IMPLIES(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "count past depth")

endmodule

// File: rtl/upe_back.sv
`include "assert_macros.svh"

module upe_back import upe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  entry_t    pop_data,
    input  logic      empty,
    output logic      pop,
    upe_out_if.source out_ch
);

    entry_t             entry_reg, entry_next;
    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic               active_reg, active_next;
    logic               final_byte;
    logic               out_accept;

    assign final_byte         = (idx_reg == entry_reg.count - 3'd1);
    assign out_accept         = out_ch.valid && out_ch.ready;
    assign out_ch.valid       = active_reg;
    assign out_ch.out_byte    = entry_reg.bytes[idx_reg];
    assign out_ch.run_last    = final_byte;
    assign out_ch.string_last = final_byte && entry_reg.str_last;

    // Load the next item as the current one drains, so bytes run back to back.
    assign pop = !empty && (!active_reg || (out_accept && final_byte));

    always_comb
    begin
        entry_next  = entry_reg;
        idx_next    = idx_reg;
        active_next = active_reg;
        if (pop)
        begin
            entry_next  = pop_data;
            idx_next    = '0;
            active_next = 1'b1;
        end
        else if (out_accept)
        begin
            if (final_byte)
                active_next = 1'b0;
            else
                idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            idx_reg    <= idx_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    `UPE_ASSERT_IMPLIES(a_idx_in_range, active_reg, idx_reg < entry_reg.count, "byte index past item length")

endmodule

// File: rtl/url_percent_encoder.sv
// An accepted item is written into the item queue and then loaded into the emitter's
// entry register, from which its first encoded byte is presented on the output.
// Throughput: one encoded byte per cycle while the output is ready; an item yields
// 0 to 7 encoded bytes, typically 1 or 3. Input items are taken every cycle while
// the item queue between classifier and emitter has room.
// Reset (rst_n low, asynchronous): drop held lookahead, empty the queue and
// the output; no clearing pass is needed.
module url_percent_encoder import upe_pkg::*;
#(
    parameter int Q_DEPTH = QUEUE_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    upe_in_if.sink    in_ch,
    upe_out_if.source out_ch
);

    logic   push;
    entry_t push_entry;
    logic   pop;
    entry_t pop_entry;
    logic   full;
    logic   empty;

    upe_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .full       (full),
        .push       (push),
        .push_entry (push_entry)
    );

    upe_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .pop       (pop),
        .pop_data  (pop_entry),
        .full      (full),
        .empty     (empty)
    );

    upe_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .pop_data (pop_entry),
        .empty    (empty),
        .pop      (pop),
        .out_ch   (out_ch)
    );

endmodule

// File: dv/upe_encoding_check.sv
`timescale 1ns / 1ps

module upe_encoding_check
    import upe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    upe_in_if    in_ch,
    upe_out_if   out_ch,
    output int   fail_count,
    output int   pending
);

    typedef struct {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_last;
    } enc_byte_t;

    localparam string URL_PUNCT = "-._~!$&'()*+,;=:@/?[]";

    enc_byte_t   encoded_fifo[$];
    logic [7:0]  run_bytes[$];
    held_stage_t lookahead;
    logic [7:0]  lookahead_digit;

    initial
    begin
        fail_count      = 0;
        pending         = 0;
        lookahead       = HELD_NONE;
        lookahead_digit = '0;
    end

    function automatic logic hex_char_in(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39)
            return 1'b1;
        if (c >= 8'h41 && c <= 8'h46)
            return 1'b1;
        return c >= 8'h61 && c <= 8'h66;
    endfunction

    function automatic logic url_safe(input logic [7:0] c);
        if ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
            (c >= 8'h30 && c <= 8'h39))
            return 1'b1;
        for (int i = 0; i < URL_PUNCT.len(); i++)
            if (URL_PUNCT[i] == c)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [7:0] hex_upper(input logic [3:0] n);
        if (n < 4'd10)
            return 8'h30 + 8'(n);
        return 8'h37 + 8'(n);
    endfunction

    task automatic emit(input logic [7:0] b);
        run_bytes.push_back(b);
    endtask

    task automatic emit_escaped(input logic [7:0] b);
        emit(PCT);
        emit(hex_upper(b[7:4]));
        emit(hex_upper(b[3:0]));
    endtask

    // Encode a byte with nothing held in front of it.
    task automatic encode_fresh(input logic [7:0] b, input logic last);
        if (b == PCT)
        begin
            if (last)
                emit_escaped(b);
            else
                lookahead = HELD_PCT;
        end
        else if (url_safe(b))
            emit(b);
        else
            emit_escaped(b);
    endtask

    task automatic encode_item(input logic [7:0] b, input logic last);
        held_stage_t stage;
        enc_byte_t   e;
        stage     = lookahead;
        lookahead = HELD_NONE;
        run_bytes.delete();
        case (stage)
            HELD_PCT:
            begin
                if (hex_char_in(b))
                begin
                    if (last)
                    begin
                        emit_escaped(PCT);
                        emit(b);
                    end
                    else
                    begin
                        lookahead       = HELD_PCT_DIGIT;
                        lookahead_digit = b;
                    end
                end
                else
                begin
                    emit_escaped(PCT);
                    encode_fresh(b, last);
                end
            end
            HELD_PCT_DIGIT:
            begin
                if (hex_char_in(b))
                begin
                    emit(PCT);
                    emit(lookahead_digit);
                    emit(b);
                end
                else
                begin
                    emit_escaped(PCT);
                    emit(lookahead_digit);
                    encode_fresh(b, last);
                end
            end
            default:
                encode_fresh(b, last);
        endcase
        if (last)
        begin
            lookahead       = HELD_NONE;
            lookahead_digit = '0;
        end
        foreach (run_bytes[i])
        begin
            e.out_byte    = run_bytes[i];
            e.run_last    = (i == run_bytes.size() - 1);
            e.string_last = e.run_last && last;
            encoded_fifo.push_back(e);
        end
    endtask

    always @(posedge clk)
    begin
        enc_byte_t want;
        if (rst_n)
        begin
            // compare before predicting: a result never stems from the same edge's item
            if (out_ch.valid && out_ch.ready)
            begin
                if (encoded_fifo.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, got byte %h run_last %b string_last %b",
                             $time, out_ch.out_byte, out_ch.run_last, out_ch.string_last);
                    fail_count++;
                end
                else
                begin
                    want = encoded_fifo.pop_front();
                    if (out_ch.out_byte !== want.out_byte)
                    begin
                        $display("%0t: out_byte mismatch, expected %h, got %h",
                                 $time, want.out_byte, out_ch.out_byte);
                        fail_count++;
                    end
                    if (out_ch.run_last !== want.run_last)
                    begin
                        $display("%0t: run_last mismatch, expected %b, got %b",
                                 $time, want.run_last, out_ch.run_last);
                        fail_count++;
                    end
                    if (out_ch.string_last !== want.string_last)
                    begin
                        $display("%0t: string_last mismatch, expected %b, got %b",
                                 $time, want.string_last, out_ch.string_last);
                        fail_count++;
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                encode_item(in_ch.in_byte, in_ch.is_last);
            pending = encoded_fifo.size();
        end
    end

endmodule

// File: dv/url_percent_encoder_tb.sv
`timescale 1ns / 1ps

module url_percent_encoder_tb;
    import upe_pkg::*;

    localparam int NUM_ITEMS   = 400;
    localparam int QUIET_AFTER = 340;

    localparam string HEX_SET = "0123456789abcdefABCDEF";

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    bit   quiet = 1'b0;
    int   fail_count;
    int   pending;
    int   sent  = 0;

    upe_in_if  in_ch ();
    upe_out_if out_ch ();

    url_percent_encoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    upe_encoding_check enc_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #1 clk = ~clk;

    initial
    begin
        #1_000_000;
        $display("FAIL url_percent_encoder");
        $finish;
    end

    // Output side: stall in bursts, then hold ready for a stretch.
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(1, 19)) @(negedge clk);
            end
            out_ch.ready = 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.in_byte = b;
        in_ch.is_last = last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        @(negedge clk);
        sent++;
    endtask

    task automatic send_text(input logic [7:0] text[$]);
        foreach (text[i])
            send_byte(text[i], i == text.size() - 1);
    endtask

    function automatic logic [7:0] any_hex();
        return HEX_SET[$urandom_range(0, HEX_SET.len() - 1)];
    endfunction

    task automatic send_random_text();
        logic [7:0] text[$];
        int         len;
        int         pick;
        len = $urandom_range(1, 12);
        while (text.size() < len)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                text.push_back(PCT);
                text.push_back(any_hex());
                text.push_back(any_hex());
            end
            else if (pick < 25)
                text.push_back(PCT);
            else if (pick < 40)
                text.push_back(any_hex());
            else if (pick < 70)
                text.push_back(8'($urandom_range(8'h20, 8'h7E)));
            else
                text.push_back(8'($urandom_range(0, 255)));
        end
        send_text(text);
    endtask

    initial
    begin
        in_ch.valid   = 1'b0;
        in_ch.in_byte = '0;
        in_ch.is_last = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_text('{8'h00, 8'hFF, "A"});
        send_text('{" ", "%"});
        send_text('{"%", "4", "1"});
        send_text('{"%", "%", "4"});
        send_text('{"%", "4", "G"});
        send_text('{"%", "a", "%", "4", "1", "~"});
        send_text('{"%", "z"});
        send_text('{"%", "f", "%"});

        // hold off until everything encoded so far has drained
        in_ch.valid = 1'b0;
        wait (pending == 0);
        @(negedge clk);

        while (sent < NUM_ITEMS)
        begin
            if (sent >= QUIET_AFTER)
                quiet = 1'b1;
            send_random_text();
        end
        in_ch.valid = 1'b0;

        wait (pending == 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("PASS url_percent_encoder");
        else
            $display("FAIL url_percent_encoder");
        $finish;
    end

endmodule

// File: url_percent_encoder.f
+incdir+rtl
rtl/upe_pkg.sv
rtl/upe_in_if.sv
rtl/upe_out_if.sv
rtl/upe_front.sv
rtl/upe_queue.sv
rtl/upe_back.sv
rtl/url_percent_encoder.sv
dv/upe_encoding_check.sv
dv/url_percent_encoder_tb.sv
